// File: design/qrm_pkg.sv
// Shared constants for the quaternion to rotation matrix block.
// Field widths and the layout of the side word that travels along the pipeline.
// No dependencies.
package qrm_pkg;

    localparam int FIELD_W    = 18;                  // width of every input and result field
    localparam int SQ_W       = 2 * FIELD_W;         // exact product of two fields
    localparam int IN_DATA_W  = 4 * FIELD_W;         // w, x, y, z
    localparam int OUT_FIELDS = 9;
    localparam int OUT_DATA_W = ((OUT_FIELDS * FIELD_W + 7) / 8) * 8;

    // Side word layout, lowest bits first: w, x, y, z, mode
    localparam int SIDE_W_LSB = 0;
    localparam int SIDE_X_LSB = FIELD_W;
    localparam int SIDE_Y_LSB = 2 * FIELD_W;
    localparam int SIDE_Z_LSB = 3 * FIELD_W;
    localparam int SIDE_MODE  = 4 * FIELD_W;
    localparam int SIDE_W     = 4 * FIELD_W + 1;

endpackage

// File: design/qrm_front.sv
// Front stages: input register, squares of x, y, z, and the clamped radicand 1 - |v|^2.
// Depends on qrm_pkg.
module qrm_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [qrm_pkg::SIDE_W-1:0]    i_side,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2*FRAC_BITS+1:0]        o_rad,
    output logic [qrm_pkg::SIDE_W-1:0]    o_side
);

    localparam int RW   = 2 * FRAC_BITS + 2;
    localparam int SUMW = qrm_pkg::SQ_W + 2;
    localparam int SW   = ((RW > SUMW) ? RW : SUMW) + 1;
    localparam logic signed [SW-1:0] ONE2 = SW'(1) << (2 * FRAC_BITS);

    logic                        r_v1, r_v2, r_v3;
    logic                        w_rdy1, w_rdy2, w_rdy3;
    logic [qrm_pkg::SIDE_W-1:0]  r_side1, r_side2, r_side3;
    logic signed [qrm_pkg::SQ_W-1:0] r_xx, r_yy, r_zz;
    logic signed [qrm_pkg::SQ_W-1:0] n_xx, n_yy, n_zz;
    logic [RW-1:0]               r_rad;
    logic [RW-1:0]               n_rad;
    logic signed [qrm_pkg::FIELD_W-1:0] w_x, w_y, w_z;
    logic signed [SUMW-1:0]      w_sum;
    logic signed [SW-1:0]        w_diff;

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    assign w_x = $signed(r_side1[qrm_pkg::SIDE_X_LSB +: qrm_pkg::FIELD_W]);
    assign w_y = $signed(r_side1[qrm_pkg::SIDE_Y_LSB +: qrm_pkg::FIELD_W]);
    assign w_z = $signed(r_side1[qrm_pkg::SIDE_Z_LSB +: qrm_pkg::FIELD_W]);

    always_comb begin
        n_xx = w_x * w_x;
        n_yy = w_y * w_y;
        n_zz = w_z * w_z;
    end

    // clamp a negative radicand to zero
    always_comb begin
        w_sum  = SUMW'(r_xx) + SUMW'(r_yy) + SUMW'(r_zz);
        w_diff = ONE2 - SW'(w_sum);
        if (w_diff[SW-1]) begin
            n_rad = '0;
        end else begin
            n_rad = w_diff[RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_side1 <= i_side;
        end
        if (w_rdy2) begin
            r_side2 <= r_side1;
            r_xx    <= n_xx;
            r_yy    <= n_yy;
            r_zz    <= n_zz;
        end
        if (w_rdy3) begin
            r_side3 <= r_side2;
            r_rad   <= n_rad;
        end
    end

    assign o_valid = r_v3;
    assign o_rad   = r_rad;
    assign o_side  = r_side3;

endmodule

// File: design/qrm_sqrt.sv
// Pipelined integer square root, one root bit per stage, floor of the exact root.
// Depends on qrm_pkg.
module qrm_sqrt #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [2*FRAC_BITS+1:0]        i_rad,
    input  logic [qrm_pkg::SIDE_W-1:0]    i_side,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [FRAC_BITS:0]            o_root,
    output logic [qrm_pkg::SIDE_W-1:0]    o_side
);

    localparam int NS   = FRAC_BITS + 1;
    localparam int RW   = 2 * FRAC_BITS + 2;
    localparam int QW   = FRAC_BITS + 1;
    localparam int REMW = FRAC_BITS + 4;

    logic                        r_v    [NS];
    logic [QW-1:0]               r_q    [NS];
    logic [REMW-1:0]             r_rem  [NS];
    logic [RW-1:0]               r_rad  [NS];
    logic [qrm_pkg::SIDE_W-1:0]  r_side [NS];
    logic [NS:0]                 w_rdy;

    assign w_rdy[NS] = i_ready;
    assign o_ready   = w_rdy[0];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        logic                        w_pv;
        logic [QW-1:0]               w_pq;
        logic [REMW-1:0]             w_prem;
        logic [RW-1:0]               w_prad;
        logic [qrm_pkg::SIDE_W-1:0]  w_pside;
        logic [REMW-1:0]             w_cur;
        logic [REMW-1:0]             w_trial;
        logic                        w_ge;
        logic [QW-1:0]               n_q;
        logic [REMW-1:0]             n_rem;
        logic [RW-1:0]               n_rad;

        if (j == 0) begin : g_first
            assign w_pv    = i_valid;
            assign w_pq    = '0;
            assign w_prem  = '0;
            assign w_prad  = i_rad;
            assign w_pside = i_side;
        end else begin : g_next
            assign w_pv    = r_v[j-1];
            assign w_pq    = r_q[j-1];
            assign w_prem  = r_rem[j-1];
            assign w_prad  = r_rad[j-1];
            assign w_pside = r_side[j-1];
        end

        assign w_rdy[j] = !r_v[j] || w_rdy[j+1];

        // bring down the next two radicand bits, try root*4 + 1
        always_comb begin
            w_cur   = {w_prem[REMW-3:0], w_prad[RW-1:RW-2]};
            w_trial = REMW'({w_pq, 2'b01});
            w_ge    = (w_cur >= w_trial);
            n_rem   = w_ge ? (w_cur - w_trial) : w_cur;
            n_q     = {w_pq[QW-2:0], w_ge};
            n_rad   = {w_prad[RW-3:0], 2'b00};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (w_rdy[j]) begin
                r_v[j] <= w_pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[j]) begin
                r_q[j]    <= n_q;
                r_rem[j]  <= n_rem;
                r_rad[j]  <= n_rad;
                r_side[j] <= w_pside;
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_root  = r_q[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

// File: design/qrm_matrix.sv
// Back stages: the nine products, the matrix entry sums, and rounding with saturation
// into the output register. Depends on qrm_pkg.
module qrm_matrix #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [FRAC_BITS:0]                i_root,
    input  logic [qrm_pkg::SIDE_W-1:0]        i_side,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [qrm_pkg::OUT_DATA_W-1:0]    o_data
);

    localparam int FW  = qrm_pkg::FIELD_W;
    localparam int QW  = FRAC_BITS + 1;
    localparam int WW  = (FRAC_BITS + 2 > FW) ? FRAC_BITS + 2 : FW;
    localparam int PW  = FW + WW;
    localparam int EW  = ((PW > 2 * FRAC_BITS + 2) ? PW : 2 * FRAC_BITS + 2) + 3;
    localparam int TW  = EW - FRAC_BITS;
    localparam int PADW = qrm_pkg::OUT_DATA_W - qrm_pkg::OUT_FIELDS * FW;
    localparam longint LIM_L = (FRAC_BITS > FW - 2) ? ((longint'(1) << (FW - 1)) - 1)
                                                    : (longint'(1) << FRAC_BITS);
    localparam logic signed [EW-1:0] ONE2 = EW'(1) << (2 * FRAC_BITS);
    localparam logic signed [EW-1:0] HALF = EW'(1) << (FRAC_BITS - 1);
    localparam logic signed [TW-1:0] LIM  = TW'(LIM_L);

    logic                   r_v1, r_v2, r_v3;
    logic                   w_rdy1, w_rdy2, w_rdy3;
    logic signed [FW-1:0]   w_x, w_y, w_z, w_win;
    logic signed [WW-1:0]   w_w;
    logic signed [qrm_pkg::SQ_W-1:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz;
    logic signed [PW-1:0]   r_xw, r_yw, r_zw;
    logic signed [EW-1:0]   n_e [qrm_pkg::OUT_FIELDS];
    logic signed [EW-1:0]   r_e [qrm_pkg::OUT_FIELDS];
    logic signed [FW-1:0]   n_out [qrm_pkg::OUT_FIELDS];
    logic signed [FW-1:0]   r_out [qrm_pkg::OUT_FIELDS];

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    assign w_win = $signed(i_side[qrm_pkg::SIDE_W_LSB +: FW]);
    assign w_x   = $signed(i_side[qrm_pkg::SIDE_X_LSB +: FW]);
    assign w_y   = $signed(i_side[qrm_pkg::SIDE_Y_LSB +: FW]);
    assign w_z   = $signed(i_side[qrm_pkg::SIDE_Z_LSB +: FW]);

    // vector-only mode takes the rebuilt scalar part
    assign w_w = i_side[qrm_pkg::SIDE_MODE] ? $signed(WW'(i_root)) : WW'(w_win);

    always_comb begin
        n_e[0] = ONE2 - (EW'(r_yy) <<< 1) - (EW'(r_zz) <<< 1);
        n_e[1] = (EW'(r_xy) <<< 1) - (EW'(r_zw) <<< 1);
        n_e[2] = (EW'(r_xz) <<< 1) + (EW'(r_yw) <<< 1);
        n_e[3] = (EW'(r_xy) <<< 1) + (EW'(r_zw) <<< 1);
        n_e[4] = ONE2 - (EW'(r_xx) <<< 1) - (EW'(r_zz) <<< 1);
        n_e[5] = (EW'(r_yz) <<< 1) - (EW'(r_xw) <<< 1);
        n_e[6] = (EW'(r_xz) <<< 1) - (EW'(r_yw) <<< 1);
        n_e[7] = (EW'(r_yz) <<< 1) + (EW'(r_xw) <<< 1);
        n_e[8] = ONE2 - (EW'(r_xx) <<< 1) - (EW'(r_yy) <<< 1);
    end

    // round half up, then clamp to plus or minus one
    always_comb begin
        logic signed [EW-1:0] v_t;
        logic signed [TW-1:0] v_r;
        for (int k = 0; k < qrm_pkg::OUT_FIELDS; k++) begin
            v_t = r_e[k] + HALF;
            v_r = $signed(v_t[EW-1:FRAC_BITS]);
            if (v_r > LIM) begin
                n_out[k] = FW'(LIM);
            end else if (v_r < -LIM) begin
                n_out[k] = FW'(-LIM);
            end else begin
                n_out[k] = v_r[FW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_xx <= w_x * w_x;
            r_yy <= w_y * w_y;
            r_zz <= w_z * w_z;
            r_xy <= w_x * w_y;
            r_xz <= w_x * w_z;
            r_yz <= w_y * w_z;
            r_xw <= w_x * w_w;
            r_yw <= w_y * w_w;
            r_zw <= w_z * w_w;
        end
        if (w_rdy2) begin
            r_e <= n_e;
        end
        if (w_rdy3) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_v3;
    assign o_data  = {{PADW{1'b0}}, r_out[8], r_out[7], r_out[6], r_out[5], r_out[4],
                      r_out[3], r_out[2], r_out[1], r_out[0]};

endmodule

// File: design/quaternion_to_rotation_matrix.sv
// Quaternion to 3x3 rotation matrix, signed fixed point with FRAC_BITS fraction bits.
// Channels: s_axis carries one quaternion per transfer, m_axis one matrix per transfer,
// and the cfg channel writes the scalar_from_vector bit (1: rebuild w from x, y, z).
// Write the cfg bit only while no item is in flight; o_cfg_ready is always high.
// The path runs through three front stages, the square root pipeline with one root bit
// per stage, and three back stages for products, sums and rounding.
// Throughput: one item per cycle in both modes unless m_axis_tready stalls the pipeline;
// every item takes the same path.
// Each stage holds its item when the stage after it is full and stalled, so s_axis_tready
// stays high while bubbles remain in the pipeline even if m_axis_tready is low; nothing
// is dropped or repeated.
// Reset (synchronous, active low) empties the pipeline and clears the cfg bit to 0.
// Depends on qrm_pkg, qrm_front, qrm_sqrt and qrm_matrix.
module quaternion_to_rotation_matrix #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // quat_w [17:0], quat_x [35:18], quat_y [53:36], quat_z [71:54]
    input  logic [qrm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // r11 [17:0], r12 [35:18], r13 [53:36], r21 [71:54], r22 [89:72],
    // r23 [107:90], r31 [125:108], r32 [143:126], r33 [161:144], zeros [167:162]
    output logic [qrm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [0:0]                        i_cfg_data
);

    logic                        r_mode;
    logic                        w_f_valid, w_f_ready;
    logic [2*FRAC_BITS+1:0]      w_f_rad;
    logic [qrm_pkg::SIDE_W-1:0]  w_f_side;
    logic                        w_s_valid, w_s_ready;
    logic [FRAC_BITS:0]          w_s_root;
    logic [qrm_pkg::SIDE_W-1:0]  w_s_side;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data[0];
        end
    end

    qrm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_side  ({r_mode, s_axis_tdata}),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_rad   (w_f_rad),
        .o_side  (w_f_side)
    );

    qrm_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_rad   (w_f_rad),
        .i_side  (w_f_side),
        .o_valid (w_s_valid),
        .i_ready (w_s_ready),
        .o_root  (w_s_root),
        .o_side  (w_s_side)
    );

    qrm_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s_valid),
        .o_ready (w_s_ready),
        .i_root  (w_s_root),
        .i_side  (w_s_side),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Testbench for quaternion_to_rotation_matrix: directed table, then random quaternions
// in both scalar modes, each checked against a typed matrix or a fixed-point predictor.
// Depends on qrm_pkg and the block under test.
module testbench;

    localparam int     FIELD_W     = qrm_pkg::FIELD_W;
    localparam int     IN_DATA_W   = qrm_pkg::IN_DATA_W;
    localparam int     OUT_DATA_W  = qrm_pkg::OUT_DATA_W;
    localparam int     OUT_FIELDS  = qrm_pkg::OUT_FIELDS;
    localparam int     FRAC_BITS   = 16;
    localparam int     LATENCY     = FRAC_BITS + 7;
    localparam int     ONE         = 1 << FRAC_BITS;
    localparam int     VEC_MAX     = 37837;           // three of these square to about 1.0
    localparam longint FIELD_MAX   = (longint'(1) <<< (FIELD_W - 1)) - 1;
    localparam int     CYCLE_LIMIT = 200000;
    localparam int     PHASE_ITEMS = 150;

    typedef struct {
        bit                      vec;
        logic [IN_DATA_W-1:0]    quat;
        bit                      typed;
        logic [OUT_DATA_W-1:0]   mat;
    } t_row;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    i_cfg_valid   = 1'b0;
    logic                    o_cfg_ready;
    logic [0:0]              i_cfg_data    = '0;

    logic [OUT_DATA_W-1:0]   pending_mats [$];
    t_row                    directed_rows [$];
    bit                      vec_mode      = 1'b0;
    bit                      gaps_on       = 1'b1;
    int                      error_count   = 0;
    int unsigned             cycle_count   = 0;
    string                   entry_name [OUT_FIELDS] =
        '{"r11", "r12", "r13", "r21", "r22", "r23", "r31", "r32", "r33"};

    quaternion_to_rotation_matrix #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [IN_DATA_W-1:0] quat_word(input int w, input int x,
                                                       input int y, input int z);
        return {z[FIELD_W-1:0], y[FIELD_W-1:0], x[FIELD_W-1:0], w[FIELD_W-1:0]};
    endfunction

    function automatic logic [OUT_DATA_W-1:0] mat_word(
        input int a11, input int a12, input int a13,
        input int a21, input int a22, input int a23,
        input int a31, input int a32, input int a33);
        int                     e [OUT_FIELDS];
        logic [OUT_DATA_W-1:0]  word;
        e = '{a11, a12, a13, a21, a22, a23, a31, a32, a33};
        word = '0;
        for (int k = 0; k < OUT_FIELDS; k++)
            word[k*FIELD_W +: FIELD_W] = e[k][FIELD_W-1:0];
        return word;
    endfunction

    // floor of the square root, one result bit at a time from the top
    function automatic longint root_floor(input longint rad);
        longint res;
        longint t;
        res = 0;
        for (int k = FRAC_BITS + 1; k >= 0; k--) begin
            t = res | (longint'(1) <<< k);
            if (t * t <= rad)
                res = t;
        end
        return res;
    endfunction

    // drop to FRAC_BITS fraction bits, ties upward, then clamp to +/- 1.0
    function automatic logic [FIELD_W-1:0] round_sat(input longint v);
        longint lim;
        longint r;
        lim = longint'(1) <<< FRAC_BITS;
        if (lim > FIELD_MAX)
            lim = FIELD_MAX;
        r = (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r[FIELD_W-1:0];
    endfunction

    function automatic logic [OUT_DATA_W-1:0] rotation_of(input logic [IN_DATA_W-1:0] q,
                                                          input bit from_vec);
        longint                 w, x, y, z;
        longint                 xx, yy, zz, one2, rad;
        longint                 e [OUT_FIELDS];
        logic [OUT_DATA_W-1:0]  word;
        w = longint'($signed(q[0 +: FIELD_W]));
        x = longint'($signed(q[FIELD_W +: FIELD_W]));
        y = longint'($signed(q[2*FIELD_W +: FIELD_W]));
        z = longint'($signed(q[3*FIELD_W +: FIELD_W]));
        xx = x * x;
        yy = y * y;
        zz = z * z;
        one2 = longint'(1) <<< (2 * FRAC_BITS);
        if (from_vec) begin
            rad = one2 - xx - yy - zz;
            if (rad < 0)
                rad = 0;
            w = root_floor(rad);
        end
        e[0] = one2 - 2 * yy - 2 * zz;
        e[1] = 2 * x * y - 2 * z * w;
        e[2] = 2 * x * z + 2 * y * w;
        e[3] = 2 * x * y + 2 * z * w;
        e[4] = one2 - 2 * xx - 2 * zz;
        e[5] = 2 * y * z - 2 * x * w;
        e[6] = 2 * x * z - 2 * y * w;
        e[7] = 2 * y * z + 2 * x * w;
        e[8] = one2 - 2 * xx - 2 * yy;
        word = '0;
        for (int k = 0; k < OUT_FIELDS; k++)
            word[k*FIELD_W +: FIELD_W] = round_sat(e[k]);
        return word;
    endfunction

    function automatic logic [IN_DATA_W-1:0] rand_quat();
        int f [4];
        int kind;
        int specials [7];
        specials = '{0, ONE, -ONE, 131071, -131072, 1, -1};
        kind = $urandom_range(3);
        for (int k = 0; k < 4; k++) begin
            case (kind)
                0: f[k] = int'($urandom());
                1: f[k] = int'($urandom_range(2 * ONE)) - ONE;
                2: f[k] = int'($urandom_range(2 * VEC_MAX)) - VEC_MAX;
                default: begin
                    if ($urandom_range(1) == 1)
                        f[k] = specials[$urandom_range(6)];
                    else
                        f[k] = int'($urandom_range(2 * ONE)) - ONE;
                end
            endcase
        end
        return quat_word(f[0], f[1], f[2], f[3]);
    endfunction

    task automatic add_row(input bit vec, input int w, input int x, input int y, input int z,
                           input bit typed = 1'b0,
                           input logic [OUT_DATA_W-1:0] mat = '0);
        t_row r;
        r.vec   = vec;
        r.quat  = quat_word(w, x, y, z);
        r.typed = typed;
        r.mat   = mat;
        directed_rows.push_back(r);
    endtask

    task automatic push_quat(input logic [IN_DATA_W-1:0] q,
                             input logic [OUT_DATA_W-1:0] want);
        while (gaps_on && $urandom_range(99) < 25) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= q;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_mats.push_back(want);
    endtask

    task automatic drain_mats();
        s_axis_tvalid <= 1'b0;
        while (pending_mats.size() != 0)
            @(posedge i_clk);
    endtask

    // change the scalar mode only with the pipeline empty
    task automatic set_mode(input bit m);
        drain_mats();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        vec_mode = m;
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= !gaps_on || ($urandom_range(99) >= 25);
    end

    always @(posedge i_clk) begin : check_mats
        logic [OUT_DATA_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_mats.size() == 0) begin
                $error("matrix transfer with none pending: %h", m_axis_tdata);
                error_count++;
            end else begin
                want = pending_mats.pop_front();
                for (int k = 0; k < OUT_FIELDS; k++) begin
                    if (m_axis_tdata[k*FIELD_W +: FIELD_W] != want[k*FIELD_W +: FIELD_W]) begin
                        $error("%s: expected %0d, actual %0d", entry_name[k],
                               $signed(want[k*FIELD_W +: FIELD_W]),
                               $signed(m_axis_tdata[k*FIELD_W +: FIELD_W]));
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [OUT_DATA_W-1:0] ident;
        logic [OUT_DATA_W-1:0] want;
        logic [IN_DATA_W-1:0]  q;
        bit                    phase_mode [6];
        phase_mode = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        ident = mat_word(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);

        // given scalar part
        add_row(0, ONE, 0, 0, 0, 1, ident);
        add_row(0, -ONE, 0, 0, 0, 1, ident);
        add_row(0, 0, 0, 0, 0, 1, ident);
        add_row(0, 0, ONE, 0, 0, 1, mat_word(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
        add_row(0, 0, 0, ONE, 0, 1, mat_word(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE));
        add_row(0, 0, 0, 0, ONE, 1, mat_word(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE));
        add_row(0, ONE, ONE, ONE, ONE, 1,
                mat_word(-ONE, 0, ONE, ONE, -ONE, 0, 0, ONE, -ONE));
        add_row(0, 131071, 131071, 131071, 131071);
        add_row(0, -131072, -131072, -131072, -131072);
        add_row(0, 131071, -131072, 131071, -131072);
        add_row(0, -1, -1, -1, -1);
        add_row(0, 46341, 46341, 0, 0);
        add_row(0, 1, 1, 1, 1);
        add_row(0, 32768, -32768, 32768, -32768);
        // scalar rebuilt from the vector part; w field ignored
        add_row(1, 0, 0, 0, 0, 1, ident);
        add_row(1, 131071, 0, 0, 0, 1, ident);
        add_row(1, 0, ONE, 0, 0, 1, mat_word(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
        // radicand below zero clamps w to zero
        add_row(1, 0, ONE, ONE, ONE, 1,
                mat_word(-ONE, ONE, ONE, ONE, -ONE, ONE, ONE, ONE, -ONE));
        add_row(1, 0, 131071, -131072, 131071);
        add_row(1, -131072, VEC_MAX, VEC_MAX, VEC_MAX);
        add_row(1, 0, 0, 0, 46341);
        add_row(1, 0, 181, -181, 1);
        add_row(1, 0, -ONE, 0, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_mode(1'b0);
        foreach (directed_rows[i]) begin
            if (directed_rows[i].vec != vec_mode)
                set_mode(directed_rows[i].vec);
            want = directed_rows[i].typed ? directed_rows[i].mat
                                          : rotation_of(directed_rows[i].quat, vec_mode);
            push_quat(directed_rows[i].quat, want);
        end

        // each phase starts from an empty pipeline; one phase runs with no idling
        for (int p = 0; p < 6; p++) begin
            set_mode(phase_mode[p]);
            gaps_on = (p != 2);
            repeat (PHASE_ITEMS) begin
                q = rand_quat();
                push_quat(q, rotation_of(q, vec_mode));
            end
        end
        gaps_on = 1'b1;

        drain_mats();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// File: sim.f
design/qrm_pkg.sv
design/qrm_front.sv
design/qrm_sqrt.sv
design/qrm_matrix.sv
design/quaternion_to_rotation_matrix.sv
tb/testbench.sv
